[rtl/cbh_pkg.sv]
// Shared types and constants of the circle brush height map.
`timescale 1ns / 1ps
package cbh_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 15;
    localparam int ROW_SLOTS  = 2 * MAX_RADIUS + 1;
    localparam int RAISE_STEP = 10;
    localparam int HEIGHT_DEPTH = MAX_WIDTH * MAX_HEIGHT * 4;
    localparam int ADDR_W = $clog2(HEIGHT_DEPTH);
    localparam int CELL_W = ADDR_W - 2;

    // Operation codes carried in the mode field.
    localparam logic [1:0] OP_BRUSH = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [7:0]  brush_x;
        logic signed [7:0]  brush_y;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic [1:0]         corner;
        logic signed [15:0] write_height;
    } item_t;

    typedef struct packed {
        logic [6:0] width;
        logic [6:0] height;
        logic [3:0] radius;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] read_height;
        logic               in_range;
        logic [10:0]        cells_raised;
    } result_t;

endpackage

[rtl/circle_brush_heightmap_raise.sv]
// Top level of the circle brush height map: ports, configuration and wiring.
`timescale 1ns / 1ps
// Usage:
// Input items arrive on the s_axis channel; each carries a mode (brush, read,
// write), a brush centre, a vertex address and a height. Every item gives
// exactly one result on m_axis: the height read, an in-range flag and the
// number of cells the brush raised.
// Configuration (map width, map height, brush radius) is written through
// cfg_wr_en, cfg_index and cfg_wdata only while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// A brush runs the circle walk, then visits the 31 row slots and raises the
// four corner vertices of each covered cell; the height memory reads and
// writes back one vertex per cycle.
// Items are processed one at a time; a two-entry queue lets the input side
// accept further items while the engine is busy or a result waits.
// Reset clears control state and the configuration to 64 x 64 cells with
// radius 4; the heights are undefined until written.
// When the receiver stalls the result is held in the output register and the
// engine takes no new item until it has been delivered.
module circle_brush_heightmap_raise (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], brush_x[9:2], brush_y[17:10], cell_x[23:18], cell_y[29:24],
    // corner[31:30], write_height[47:32]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_height[15:0], in_range[16], cells_raised[27:17], zero[31:28]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    logic [6:0] width_reg, height_reg;
    logic [3:0] radius_reg;
    cbh_pkg::cfg_t cfg;
    logic push, full, pop, q_valid;
    cbh_pkg::item_t push_item, head;
    cbh_pkg::result_t result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            radius_reg <= 4'd4;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cbh_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                cbh_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                cbh_pkg::REG_RADIUS: radius_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Map sizes beyond the storage act as the largest size.
    always_comb
    begin
        cfg.width  = (width_reg > 7'(cbh_pkg::MAX_WIDTH)) ? 7'(cbh_pkg::MAX_WIDTH) : width_reg;
        cfg.height = (height_reg > 7'(cbh_pkg::MAX_HEIGHT)) ? 7'(cbh_pkg::MAX_HEIGHT)
                                                             : height_reg;
        cfg.radius = (radius_reg > 4'(cbh_pkg::MAX_RADIUS)) ? 4'(cbh_pkg::MAX_RADIUS)
                                                             : radius_reg;
    end

    cbh_front u_front (
        .tvalid    (s_axis_tvalid),
        .tready    (s_axis_tready),
        .tdata     (s_axis_tdata),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    cbh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (head)
    );

    cbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (head),
        .q_pop      (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {4'd0, result.cells_raised, result.in_range, result.read_height};

endmodule

[rtl/cbh_front.sv]
// Front end: unpacks and classifies input items for the queue.
`timescale 1ns / 1ps
module cbh_front (
    input  logic                            tvalid,
    output logic                            tready,
    input  logic [cbh_pkg::IN_DATA_W-1:0]   tdata,
    output logic                            push,
    output cbh_pkg::item_t                  push_item,
    input  logic                            full
);

    cbh_pkg::item_t item;

    // Unpack fields from the lowest bit up; unused mode codes become no-ops.
    always_comb
    begin
        item.op           = tdata[1:0];
        item.brush_x      = tdata[9:2];
        item.brush_y      = tdata[17:10];
        item.cell_x       = tdata[23:18];
        item.cell_y       = tdata[29:24];
        item.corner       = tdata[31:30];
        item.write_height = tdata[47:32];
        case (tdata[1:0])
            cbh_pkg::OP_BRUSH, cbh_pkg::OP_READ, cbh_pkg::OP_WRITE: item.op = tdata[1:0];
            default: item.op = cbh_pkg::OP_NONE;
        endcase
    end

    assign tready    = !full;
    assign push      = tvalid && !full;
    assign push_item = item;

endmodule

[rtl/cbh_queue.sv]
// Two-entry queue between the front end and the execution engine.
`timescale 1ns / 1ps
module cbh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbh_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output cbh_pkg::item_t head
);

    cbh_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/cbh_back.sv]
// Execution engine: circle walk, span filling, height memory and result register.
`timescale 1ns / 1ps
module cbh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cbh_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  cbh_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output cbh_pkg::result_t  out_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_SLOT   = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam int RS = cbh_pkg::ROW_SLOTS;
    localparam int AW = cbh_pkg::ADDR_W;
    localparam int CW = cbh_pkg::CELL_W;

    logic [2:0] state_reg, state_next;
    cbh_pkg::item_t item_reg, item_next;
    logic [4:0] ext_reg [RS];
    logic [4:0] ext_next [RS];
    logic [4:0] scan_x_reg, scan_x_next;
    logic [4:0] scan_y_reg, scan_y_next;
    logic signed [7:0] decision_reg, decision_next;
    logic [4:0] slot_reg, slot_next;
    logic [CW-1:0] row_base_reg, row_base_next;
    logic [5:0] col_reg, col_next;
    logic [5:0] hi_reg, hi_next;
    logic [1:0] corner_reg, corner_next;
    logic [10:0] count_reg, count_next;
    logic inr_reg, inr_next;
    logic out_valid_reg, out_valid_next;
    cbh_pkg::result_t out_reg, out_next;
    logic pend_reg;
    logic [AW-1:0] pend_addr_reg;

    logic signed [15:0] heights [cbh_pkg::HEIGHT_DEPTH];
    logic signed [15:0] rd_data_reg;
    logic mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic signed [15:0] mem_wdata;

    logic signed [16:0] raised_sum;
    logic signed [15:0] raised_val;
    logic [12:0] vtx_prod;
    logic [CW-1:0] vtx_cell;
    logic vtx_in;
    logic signed [9:0] row_s, lo_s, hi_s, lo_c, hi_c, cx_s;
    logic signed [9:0] w_s, h_s;
    logic [4:0] slot_ext;
    logic slot_ok;
    logic [12:0] row_prod;
    logic signed [7:0] dec_step;
    logic [4:0] sy0, sy1, sx0, sx1;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Saturating raise of the vertex read in the previous cycle.
    always_comb
    begin
        raised_sum = {rd_data_reg[15], rd_data_reg} + 17'(cbh_pkg::RAISE_STEP);
        raised_val = (raised_sum > 17'sd32767) ? 16'sh7fff : raised_sum[15:0];
    end

    // Vertex address for single reads and writes.
    always_comb
    begin
        vtx_prod = 13'(q_item.cell_y) * 13'(cfg.width);
        vtx_cell = vtx_prod[CW-1:0] + CW'(q_item.cell_x);
        vtx_in   = ({1'b0, q_item.cell_x} < cfg.width) && ({1'b0, q_item.cell_y} < cfg.height);
    end

    // Span of the current row slot, clipped to the map.
    always_comb
    begin
        w_s   = $signed({3'b000, cfg.width});
        h_s   = $signed({3'b000, cfg.height});
        slot_ext = ext_reg[slot_reg[4:0] < 5'(RS) ? slot_reg : 5'd0];
        cx_s  = 10'(item_reg.brush_x);
        row_s = 10'(item_reg.brush_y) + 10'(slot_reg) - 10'(cbh_pkg::MAX_RADIUS);
        lo_s  = cx_s - 10'(slot_ext);
        hi_s  = cx_s + 10'(slot_ext) - 10'sd1;
        lo_c  = (lo_s < 10'sd0) ? 10'sd0 : lo_s;
        hi_c  = (hi_s > w_s - 10'sd1) ? w_s - 10'sd1 : hi_s;
        slot_ok = (slot_ext != 5'd0) && (row_s >= 10'sd0) && (row_s < h_s)
                  && (lo_c <= hi_c);
        row_prod = 13'(row_s[5:0]) * 13'(cfg.width);
    end

    // Slots marked by one step of the midpoint walk.
    always_comb
    begin
        sy0 = 5'(cbh_pkg::MAX_RADIUS) + scan_y_reg;
        sy1 = 5'(cbh_pkg::MAX_RADIUS) - scan_y_reg;
        sx0 = 5'(cbh_pkg::MAX_RADIUS) + scan_x_reg;
        sx1 = 5'(cbh_pkg::MAX_RADIUS) - scan_x_reg;
        dec_step = decision_reg + 8'({scan_x_reg, 1'b1});
    end

    // Main sequencer.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_x_next   = scan_x_reg;
        scan_y_next   = scan_y_reg;
        decision_next = decision_reg;
        slot_next     = slot_reg;
        row_base_next = row_base_reg;
        col_next      = col_reg;
        hi_next       = hi_reg;
        corner_next   = corner_reg;
        count_next    = count_reg;
        inr_next      = inr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next      = out_reg;
        q_pop         = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        mem_we        = pend_reg;
        mem_waddr     = pend_addr_reg;
        mem_wdata     = raised_val;
        for (int s = 0; s < RS; s++)
        begin
            ext_next[s] = ext_reg[s];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    case (q_item.op)
                        cbh_pkg::OP_BRUSH:
                        begin
                            for (int s = 0; s < RS; s++)
                            begin
                                ext_next[s] = 5'd0;
                            end
                            scan_x_next   = 5'd0;
                            scan_y_next   = 5'(cfg.radius);
                            decision_next = -8'(cfg.radius);
                            count_next    = 11'd0;
                            inr_next = (q_item.brush_x >= 0) && (q_item.brush_y >= 0)
                                       && (10'(q_item.brush_x) < 10'(cfg.width))
                                       && (10'(q_item.brush_y) < 10'(cfg.height));
                            // A zero radius covers no cell, so the walk is skipped.
                            state_next = (cfg.radius == 4'd0) ? ST_DONE : ST_WALK;
                        end
                        cbh_pkg::OP_READ:
                        begin
                            mem_re    = vtx_in;
                            mem_raddr = {vtx_cell, q_item.corner};
                            inr_next  = vtx_in;
                            state_next = ST_RDWAIT;
                        end
                        cbh_pkg::OP_WRITE:
                        begin
                            mem_we    = vtx_in;
                            mem_waddr = {vtx_cell, q_item.corner};
                            mem_wdata = q_item.write_height;
                            out_valid_next = 1'b1;
                            out_next.read_height  = 16'sd0;
                            out_next.in_range     = vtx_in;
                            out_next.cells_raised = 11'd0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next = '0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (scan_x_reg <= scan_y_reg)
                begin
                    for (int s = 0; s < RS; s++)
                    begin
                        if ((5'(s) == sy0 || 5'(s) == sy1) && scan_x_reg > ext_next[s])
                        begin
                            ext_next[s] = scan_x_reg;
                        end
                        if ((5'(s) == sx0 || 5'(s) == sx1) && scan_y_reg > ext_next[s])
                        begin
                            ext_next[s] = scan_y_reg;
                        end
                    end
                    scan_x_next = scan_x_reg + 5'd1;
                    if (dec_step >= 0)
                    begin
                        scan_y_next   = scan_y_reg - 5'd1;
                        decision_next = dec_step - 8'({scan_y_reg - 5'd1, 1'b0});
                    end
                    else
                    begin
                        decision_next = dec_step;
                    end
                end
                else
                begin
                    slot_next  = 5'd0;
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                slot_next = slot_reg + 5'd1;
                if (slot_ok)
                begin
                    row_base_next = row_prod[CW-1:0];
                    col_next      = lo_c[5:0];
                    hi_next       = hi_c[5:0];
                    corner_next   = 2'd0;
                    state_next    = ST_RUN;
                end
                else if (slot_reg == 5'(RS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                // One vertex read per cycle; the raised value is written back once the read data is registered.
                mem_re      = 1'b1;
                mem_raddr   = {row_base_reg + CW'(col_reg), corner_reg};
                corner_next = corner_reg + 2'd1;
                if (corner_reg == 2'd3)
                begin
                    count_next = count_reg + 11'd1;
                    col_next   = col_reg + 6'd1;
                    if (col_reg == hi_reg)
                    begin
                        state_next = (slot_reg == 5'(RS)) ? ST_DONE : ST_SLOT;
                    end
                end
            end
            ST_RDWAIT:
            begin
                out_valid_next = 1'b1;
                out_next.read_height  = inr_reg ? rd_data_reg : 16'sd0;
                out_next.in_range     = inr_reg;
                out_next.cells_raised = 11'd0;
                state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_next.read_height  = 16'sd0;
                out_next.in_range     = inr_reg;
                out_next.cells_raised = count_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_x_reg    <= 5'd0;
            scan_y_reg    <= 5'd0;
            decision_reg  <= 8'sd0;
            slot_reg      <= 5'd0;
            corner_reg    <= 2'd0;
            count_reg     <= 11'd0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int s = 0; s < RS; s++)
            begin
                ext_reg[s] <= 5'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_x_reg    <= scan_x_next;
            scan_y_reg    <= scan_y_next;
            decision_reg  <= decision_next;
            slot_reg      <= slot_next;
            corner_reg    <= corner_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= mem_re && (state_reg == ST_RUN);
            for (int s = 0; s < RS; s++)
            begin
                ext_reg[s] <= ext_next[s];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        row_base_reg  <= row_base_next;
        col_reg       <= col_next;
        hi_reg        <= hi_next;
        inr_reg       <= inr_next;
        out_reg       <= out_next;
        pend_addr_reg <= mem_raddr;
    end

    // Height memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heights[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= heights[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_pend_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_RUN))
        else $error("raise write without a span read");
    // The last step of the walk may pass the diagonal by two columns.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ({1'b0, scan_x_reg} <= {1'b0, scan_y_reg} + 6'd2))
        else $error("circle walk overran");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 11'd1024)
        else $error("raised cell count out of range");
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg)
        else $error("item taken while a result waits");
`endif

endmodule

[tb/cbh_checker.sv]
// Checker for the circle brush height map: predicts every result and compares it.
`timescale 1ns / 1ps
module cbh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          brushes
);

    typedef struct packed {
        logic [15:0] read_height;
        logic        in_range;
        logic [10:0] cells_raised;
    } outcome_t;

    // Shadow of the block's state and configuration.
    shortint     vertex_h [cbh_pkg::HEIGHT_DEPTH];
    int unsigned span_ext [cbh_pkg::ROW_SLOTS];
    bit          span_seen [cbh_pkg::ROW_SLOTS];
    int unsigned shadow_w;
    int unsigned shadow_h;
    int unsigned shadow_r;
    outcome_t    outcome_q [$];

    assign pending = outcome_q.size();

    // Keep only the widest span seen for each row offset.
    function automatic void note_span(int off, int ext);
        int slot;
        slot = off + cbh_pkg::MAX_RADIUS;
        if (slot < 0 || slot >= cbh_pkg::ROW_SLOTS || ext < 0)
            return;
        if (!span_seen[slot] || ext > span_ext[slot])
            span_ext[slot] = ext;
        span_seen[slot] = 1'b1;
    endfunction

    // Walk the midpoint circle, then raise every covered cell of the map.
    function automatic int unsigned paint_circle(int cx, int cy, int w, int h);
        int r;
        int px;
        int py;
        int bal;
        int row;
        int lo;
        int hi;
        int idx;
        int v;
        int unsigned count;
        r = (shadow_r > cbh_pkg::MAX_RADIUS) ? cbh_pkg::MAX_RADIUS : shadow_r;
        count = 0;
        for (int s = 0; s < cbh_pkg::ROW_SLOTS; s++)
        begin
            span_ext[s] = 0;
            span_seen[s] = 1'b0;
        end
        px = 0;
        py = r;
        bal = -r;
        while (px <= py)
        begin
            note_span(py, px);
            note_span(-py, px);
            note_span(px, py);
            note_span(-px, py);
            bal += 2 * px + 1;
            px++;
            if (bal >= 0)
            begin
                py--;
                bal -= 2 * py;
            end
        end
        for (int s = 0; s < cbh_pkg::ROW_SLOTS; s++)
        begin
            if (!span_seen[s] || span_ext[s] == 0)
                continue;
            row = cy + s - cbh_pkg::MAX_RADIUS;
            if (row < 0 || row >= h)
                continue;
            lo = cx - int'(span_ext[s]);
            hi = cx + int'(span_ext[s]) - 1;
            if (lo < 0)
                lo = 0;
            if (hi > w - 1)
                hi = w - 1;
            for (int x = lo; x <= hi; x++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    idx = (row * w + x) * 4 + c;
                    if (idx < 0 || idx >= cbh_pkg::HEIGHT_DEPTH)
                        continue;
                    v = int'(vertex_h[idx]) + cbh_pkg::RAISE_STEP;
                    if (v > 32767)
                        v = 32767;
                    vertex_h[idx] = shortint'(v);
                end
                count++;
            end
        end
        return count;
    endfunction

    // Work out the result of one accepted item and update the shadow state.
    function automatic outcome_t predict_item(logic [47:0] d);
        outcome_t o;
        logic [1:0] op;
        int w;
        int h;
        int x;
        int y;
        int idx;
        op = d[1:0];
        w = (shadow_w > cbh_pkg::MAX_WIDTH) ? cbh_pkg::MAX_WIDTH : shadow_w;
        h = (shadow_h > cbh_pkg::MAX_HEIGHT) ? cbh_pkg::MAX_HEIGHT : shadow_h;
        o = '0;
        if (op == cbh_pkg::OP_BRUSH)
        begin
            x = int'($signed(d[9:2]));
            y = int'($signed(d[17:10]));
            o.in_range = (x >= 0 && y >= 0 && x < w && y < h);
            o.cells_raised = 11'(paint_circle(x, y, w, h));
            brushes++;
        end
        else if (op == cbh_pkg::OP_READ || op == cbh_pkg::OP_WRITE)
        begin
            x = d[23:18];
            y = d[29:24];
            if (x < w && y < h)
            begin
                idx = (y * w + x) * 4 + d[31:30];
                o.in_range = 1'b1;
                if (op == cbh_pkg::OP_READ)
                    o.read_height = vertex_h[idx];
                else
                    vertex_h[idx] = shortint'($signed(d[47:32]));
            end
        end
        return o;
    endfunction

    initial
    begin
        errors = 0;
        checked = 0;
        brushes = 0;
        shadow_w = cbh_pkg::MAX_WIDTH;
        shadow_h = cbh_pkg::MAX_HEIGHT;
        shadow_r = 4;
        foreach (vertex_h[i])
            vertex_h[i] = 0;
    end

    // Follow configuration writes.
    always @(posedge clk)
    begin
        if (rst_n && cfg_wr_en)
        begin
            case (cfg_index)
                cbh_pkg::REG_WIDTH:  shadow_w = cfg_wdata;
                cbh_pkg::REG_HEIGHT: shadow_h = cfg_wdata;
                cbh_pkg::REG_RADIUS: shadow_r = cfg_wdata[3:0];
                default:    ;
            endcase
        end
    end

    // Predict each accepted input item and compare each delivered result.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            outcome_q.push_back(predict_item(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[27:17]};
            if (outcome_q.size() == 0)
            begin
                $error("result item with no expectation waiting: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                checked++;
                if (got.read_height !== want.read_height)
                begin
                    $error("read_height: expected %0d, got %0d",
                           $signed(want.read_height), $signed(got.read_height));
                    errors++;
                end
                if (got.in_range !== want.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
                    errors++;
                end
                if (got.cells_raised !== want.cells_raised)
                begin
                    $error("cells_raised: expected %0d, got %0d",
                           want.cells_raised, got.cells_raised);
                    errors++;
                end
            end
        end
    end

endmodule

[tb/circle_brush_heightmap_raise_tb.sv]
// Testbench top for the circle brush height map: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module circle_brush_heightmap_raise_tb;

    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_ITEMS = 800;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_wdata;

    int errors;
    int pending;
    int checked;
    int brushes;
    int cycles;
    bit gapless;
    int stall_left;

    // Which vertices hold a written height, so that reads only hit those.
    bit vertex_known [cbh_pkg::HEIGHT_DEPTH];
    int known_list [$];
    int cur_w;
    int cur_h;

    circle_brush_heightmap_raise u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    cbh_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .brushes       (brushes)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Give up if the run does not finish in time.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: unless gapless, stall for a random number of cycles after each item.
    initial
        stall_left = 0;

    always @(posedge clk)
    begin
        int n;
        n = stall_left;
        if (m_axis_tvalid && m_axis_tready)
            n = gapless ? 0 : $urandom_range(0, 16);
        if (n > 0)
        begin
            stall_left <= n - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_left <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one item after a random gap (none when gapless) and hold it until it is taken.
    task automatic send_item(cbh_pkg::item_t it);
        int gap;
        int idx;
        gap = gapless ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.write_height, it.corner, it.cell_y, it.cell_x,
                         it.brush_y, it.brush_x, it.op};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        if (it.op == cbh_pkg::OP_WRITE && it.cell_x < cur_w && it.cell_y < cur_h)
        begin
            idx = (it.cell_y * cur_w + it.cell_x) * 4 + it.corner;
            if (!vertex_known[idx])
                known_list.push_back(idx);
            vertex_known[idx] = 1'b1;
        end
    endtask

    // Wait until every expected result has been delivered.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_map(int w, int h, int r);
        write_reg(cbh_pkg::REG_WIDTH, 7'(w));
        write_reg(cbh_pkg::REG_HEIGHT, 7'(h));
        write_reg(cbh_pkg::REG_RADIUS, 7'(r));
        cur_w = (w > cbh_pkg::MAX_WIDTH) ? cbh_pkg::MAX_WIDTH : w;
        cur_h = (h > cbh_pkg::MAX_HEIGHT) ? cbh_pkg::MAX_HEIGHT : h;
    endtask

    function automatic cbh_pkg::item_t vertex_op(logic [1:0] op, int x, int y, int c, int v);
        cbh_pkg::item_t it;
        it = '0;
        it.op = op;
        it.brush_x = 8'($urandom);
        it.brush_y = 8'($urandom);
        it.cell_x = 6'(x);
        it.cell_y = 6'(y);
        it.corner = 2'(c);
        it.write_height = 16'(v);
        return it;
    endfunction

    function automatic cbh_pkg::item_t brush_at(int x, int y);
        cbh_pkg::item_t it;
        it = vertex_op(cbh_pkg::OP_BRUSH, $urandom, $urandom, $urandom, $urandom);
        it.brush_x = 8'(x);
        it.brush_y = 8'(y);
        return it;
    endfunction

    // Draw one random item: mostly brushes, writes and reads of known vertices.
    function automatic cbh_pkg::item_t random_item();
        cbh_pkg::item_t it;
        int pick;
        int idx;
        int cell_no;
        int span;
        pick = $urandom_range(0, 99);
        it = vertex_op(cbh_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
        if (pick < 35)
        begin
            span = 17;
            if ($urandom_range(0, 9) == 0)
                it = brush_at($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128);
            else
                it = brush_at($urandom_range(0, cur_w + 2 * span) - span,
                              $urandom_range(0, cur_h + 2 * span) - span);
        end
        else if (pick < 62 && cur_w > 0 && cur_h > 0)
            it = vertex_op(cbh_pkg::OP_WRITE, $urandom_range(0, cur_w - 1),
                           $urandom_range(0, cur_h - 1), $urandom, $urandom);
        else if (pick < 90 && known_list.size() > 0 && cur_w > 0)
        begin
            idx = known_list[$urandom_range(0, known_list.size() - 1)];
            cell_no = idx / 4;
            if (cell_no / cur_w < cur_h)
                it = vertex_op(cbh_pkg::OP_READ, cell_no % cur_w, cell_no / cur_w, idx % 4,
                               $urandom);
            else
                it = vertex_op(cbh_pkg::OP_WRITE, $urandom, 63, $urandom, $urandom);
        end
        else if (pick < 95)
        begin
            // Vertex access that may fall off the map; only writes are random here.
            it.op = cbh_pkg::OP_WRITE;
            if (cur_w < 64)
                it.cell_x = 6'($urandom_range(cur_w, 63));
        end
        return it;
    endfunction

    initial
    begin
        int cfg_w [8];
        int cfg_h [8];
        int cfg_r [8];
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= cbh_pkg::REG_WIDTH;
        cfg_wdata <= '0;
        gapless = 1'b0;
        cur_w = cbh_pkg::MAX_WIDTH;
        cur_h = cbh_pkg::MAX_HEIGHT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: height extremes, saturation, every mode, off-map brushes.
        send_item(vertex_op(cbh_pkg::OP_WRITE, 0, 0, 0, 32767));
        send_item(vertex_op(cbh_pkg::OP_WRITE, 0, 0, 1, 32760));
        send_item(vertex_op(cbh_pkg::OP_WRITE, 0, 0, 2, -32768));
        send_item(vertex_op(cbh_pkg::OP_WRITE, 63, 63, 3, -1));
        send_item(vertex_op(cbh_pkg::OP_WRITE, 1, 0, 3, 32765));
        send_item(brush_at(0, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 0, 0, 0, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 0, 0, 1, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 0, 0, 2, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 1, 0, 3, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 63, 63, 3, 0));
        send_item(vertex_op(cbh_pkg::OP_NONE, 63, 63, 3, -1));
        send_item(brush_at(-128, -128));
        send_item(brush_at(127, 127));
        send_item(brush_at(63, 63));
        send_item(brush_at(-4, 30));
        drain();
        set_map(1, 1, 0);
        send_item(brush_at(0, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 0, 0, 0, 0));
        send_item(vertex_op(cbh_pkg::OP_READ, 63, 63, 3, 0));
        send_item(vertex_op(cbh_pkg::OP_WRITE, 1, 0, 0, 5));
        drain();
        set_map(127, 127, 15);
        send_item(brush_at(32, 32));
        send_item(vertex_op(cbh_pkg::OP_READ, 63, 63, 3, 0));

        // Random phases over several map shapes, the extremes included.
        cfg_w = '{64, 1, 127, 0, 10, 33, 64, 0};
        cfg_h = '{64, 1, 127, 5, 7, 64, 1, 0};
        cfg_r = '{15, 0, 15, 3, 1, 7, 15, 0};
        for (int p = 0; p < 10; p++)
        begin
            drain();
            if (p < 8)
                set_map(cfg_w[p], cfg_h[p], cfg_r[p]);
            else
                set_map($urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 15));
            for (int i = 0; i < RANDOM_ITEMS / 10; i++)
            begin
                if (i % 20 == 0)
                    gapless = ($urandom_range(0, 3) == 0);
                send_item(random_item());
            end
        end
        gapless = 1'b0;
        drain();
        repeat (50) @(posedge clk);

        $display("Checked %0d result items, %0d of them brush strokes, over ten map shapes.",
                 checked, brushes);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/cbh_pkg.sv
rtl/cbh_front.sv
rtl/cbh_queue.sv
rtl/cbh_back.sv
rtl/circle_brush_heightmap_raise.sv
tb/cbh_checker.sv
tb/circle_brush_heightmap_raise_tb.sv
